// ----- design/miss_history_prefetcher_core_assert.svh -----
// Assertion macros used by the prefetcher back end.
`ifndef MISS_HISTORY_PREFETCHER_CORE_ASSERT_SVH
`define MISS_HISTORY_PREFETCHER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MHP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`define MHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define MHP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define MHP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/mhp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mhp_pkg;

    localparam int ADDR_W = 64;

    typedef struct packed {
        logic              is_miss;
        logic [ADDR_W-1:0] access_address;
    } in_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0] prefetch_address;
        logic              last_of_run;
    } out_word_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] access_address;
    } queue_head_t;

endpackage

`default_nettype wire

// ----- design/mhp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mhp_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mhp_pkg::in_word_t   s_data,
    input  wire logic                pop,
    output mhp_pkg::queue_head_t     head
);
    import mhp_pkg::*;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [ADDR_W-1:0] queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              do_pop;

    // Hits are taken and dropped here; only misses reach the back end.
    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready && s_data.is_miss;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid          = (count_reg != '0);
    assign head.access_address = queue_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= s_data.access_address;
        end
    end

endmodule

`default_nettype wire

// ----- design/mhp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "miss_history_prefetcher_core_assert.svh"

module mhp_back #(
    parameter int STORE_DEPTH = 64,
    parameter int FETCH_SPAN  = 3
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire mhp_pkg::queue_head_t head,
    output logic                      pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output mhp_pkg::out_word_t        m_data
);
    import mhp_pkg::*;

    localparam int IDX_W  = $clog2(STORE_DEPTH);
    localparam int SPAN_W = $clog2(FETCH_SPAN);
    localparam logic [IDX_W:0] DEPTH_C = (IDX_W + 1)'(STORE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(STORE_DEPTH - 1);
    localparam logic [SPAN_W-1:0] LAST_RUN = SPAN_W'(FETCH_SPAN - 2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_ERD  = 3'd4;
    localparam logic [2:0] S_EOUT = 3'd5;

    logic [ADDR_W-1:0]      mem [STORE_DEPTH];
    logic [ADDR_W-1:0]      rd_data_reg;
    logic [ADDR_W-1:0]      key_reg;
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [IDX_W-1:0]       wp_reg;
    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [IDX_W:0]         k_reg;
    logic [IDX_W:0]         k_next;
    logic [SPAN_W-1:0]      n_reg;
    logic [SPAN_W-1:0]      n_next;
    logic                   out_valid_reg;
    out_word_t              out_reg;

    logic [IDX_W:0] k_inc;
    logic           k_end;
    logic           inc_end;
    logic           cur_valid;
    logic           inc_valid;
    logic           run_last;
    logic           mem_we;
    logic           mem_re;
    logic           key_load;
    logic           load_out;

    assign k_inc     = k_reg + (IDX_W + 1)'(1);
    assign k_end     = (k_reg == DEPTH_C);
    assign inc_end   = (k_inc == DEPTH_C);
    assign cur_valid = valid_reg[k_reg[IDX_W-1:0]];
    assign inc_valid = valid_reg[k_inc[IDX_W-1:0]];
    assign run_last  = inc_end || !inc_valid || (n_reg == LAST_RUN);

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        pop        = 1'b0;
        key_load   = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (head.valid) begin
                    pop        = 1'b1;
                    key_load   = 1'b1;
                    k_next     = '0;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                if (k_end || !cur_valid) begin
                    state_next = S_WR;
                end else begin
                    mem_re     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                k_next = k_inc;
                if (rd_data_reg == key_reg) begin
                    n_next     = '0;
                    state_next = (inc_end || !inc_valid) ? S_IDLE : S_ERD;
                end else begin
                    state_next = S_RD;
                end
            end
            S_WR: begin
                mem_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_ERD: begin
                mem_re     = 1'b1;
                state_next = S_EOUT;
            end
            S_EOUT: begin
                if (!out_valid_reg || m_ready) begin
                    load_out = 1'b1;
                    if (run_last) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_inc;
                        n_next     = n_reg + SPAN_W'(1);
                        state_next = S_ERD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            n_reg         <= '0;
            wp_reg        <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            if (mem_we) begin
                valid_reg[wp_reg] <= 1'b1;
                wp_reg <= (wp_reg == LAST_SLOT) ? '0 : wp_reg + IDX_W'(1);
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (key_load) begin
            key_reg <= head.access_address;
        end
        if (load_out) begin
            out_reg.prefetch_address <= rd_data_reg;
            out_reg.last_of_run      <= run_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg] <= key_reg;
        end
        if (mem_re) begin
            rd_data_reg <= mem[k_reg[IDX_W-1:0]];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `MHP_ASSERT_IMPLY(a_pop_has_head, aclk, aresetn, pop, head.valid)
    `MHP_ASSERT_IMPLY(a_cmp_in_range, aclk, aresetn, state_reg == S_CMP, !k_end)
    `MHP_ASSERT_IMPLY(a_emit_valid_slot, aclk, aresetn, state_reg == S_ERD,
        !k_end && cur_valid)
    `MHP_ASSERT_IMPLY(a_out_from_emit, aclk, aresetn, $rose(out_valid_reg),
        $past(state_reg) == S_EOUT)

endmodule

`default_nettype wire

// ----- design/miss_history_prefetcher_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Miss-history correlation prefetcher. Each input word is one cache access;
// hits are taken and give no result, misses go through a two-entry queue to
// a search engine with a single-port history memory whose read data is
// registered. A miss is compared against one stored entry at a time, each
// in a read state and a compare state, from slot 0 up to the first unwritten
// slot or the table end; a new address is then recorded at the wrapping
// write pointer. A match at slot h is followed by up to FETCH_SPAN - 1
// prefetch words, each read and then emitted when the output register is
// free, taken from the valid slots after h without wrapping past the table
// end; the final word carries last_of_run. Results wait in an output
// register while new accesses enter the queue until it is full.
module miss_history_prefetcher_core #(
    parameter int STORE_DEPTH = 64,
    parameter int FETCH_SPAN  = 3
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire mhp_pkg::in_word_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output mhp_pkg::out_word_t      m_data
);
    import mhp_pkg::*;

    queue_head_t head;
    logic        pop;

    mhp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .pop     (pop),
        .head    (head)
    );

    mhp_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .FETCH_SPAN  (FETCH_SPAN)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- tb/tb_miss_history_prefetcher_core.sv -----
`timescale 1ns / 1ps

module tb_miss_history_prefetcher_core;

    import mhp_pkg::*;

    localparam int STORE_DEPTH  = 64;
    localparam int FETCH_SPAN   = 3;
    localparam int SLOT_W       = $clog2(STORE_DEPTH);
    localparam int MISS_ITEMS   = 450;
    localparam int IDLE_PCT     = 31;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 600;
    localparam int PAUSE_AT     = 350;
    localparam int BUSY_FROM    = 420;
    localparam int BUSY_TO      = 520;
    localparam int DRAIN_CYCLES = 2 * STORE_DEPTH + 4 * FETCH_SPAN + 40;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    in_word_t  pending_words[$];
    out_word_t expected_prefetches[$];

    logic [ADDR_W-1:0] miss_table_addr[STORE_DEPTH];
    logic              miss_table_valid[STORE_DEPTH];
    logic [SLOT_W-1:0] next_slot;

    int  in_accepted = 0;
    int  sent_count = 0;
    int  errors = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  pause_done = 1'b0;
    wire busy_stretch = (in_accepted >= BUSY_FROM) && (in_accepted < BUSY_TO);

    miss_history_prefetcher_core #(
        .STORE_DEPTH(STORE_DEPTH),
        .FETCH_SPAN (FETCH_SPAN)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #10 aclk = ~aclk;

    // A miss either records a new address or yields up to FETCH_SPAN - 1 valid slots that follow its match.
    task automatic apply_access(input in_word_t w);
        int        hit_slot;
        int        run_len;
        int        k;
        out_word_t r;
        hit_slot = -1;
        run_len = 0;
        if (!w.is_miss) begin
            return;
        end
        for (k = 0; k < STORE_DEPTH; k++) begin
            if (miss_table_valid[k] && miss_table_addr[k] == w.access_address) begin
                hit_slot = k;
                break;
            end
        end
        if (hit_slot < 0) begin
            miss_table_addr[next_slot] = w.access_address;
            miss_table_valid[next_slot] = 1'b1;
            next_slot = next_slot + 1'b1;
            return;
        end
        for (k = hit_slot + 1; k < STORE_DEPTH && k < hit_slot + FETCH_SPAN; k++) begin
            if (!miss_table_valid[k]) begin
                break;
            end
            run_len++;
        end
        for (k = 0; k < run_len; k++) begin
            r.prefetch_address = miss_table_addr[hit_slot + 1 + k];
            r.last_of_run = (k == run_len - 1);
            expected_prefetches.push_back(r);
        end
    endtask

    task automatic add_access(input logic miss, input logic [ADDR_W-1:0] addr);
        in_word_t w;
        w.is_miss = miss;
        w.access_address = addr;
        pending_words.push_back(w);
    endtask

    initial begin
        logic [ADDR_W-1:0] recent[$];
        logic [ADDR_W-1:0] addr;
        int                misses;
        int                pick;
        for (int k = 0; k < STORE_DEPTH; k++) begin
            miss_table_valid[k] = 1'b0;
            miss_table_addr[k] = '0;
        end
        next_slot = '0;

        add_access(1'b0, '0);
        add_access(1'b0, '1);
        add_access(1'b1, '0);
        add_access(1'b1, '1);
        add_access(1'b1, {(ADDR_W/2){2'b01}});
        add_access(1'b1, {(ADDR_W/2){2'b10}});
        add_access(1'b1, '0);
        add_access(1'b1, {(ADDR_W/2){2'b10}});
        add_access(1'b1, {(ADDR_W/2){2'b01}});
        add_access(1'b0, '0);
        add_access(1'b1, '1);
        add_access(1'b1, 64'h0000_0000_0000_0001);
        add_access(1'b1, 64'h8000_0000_0000_0000);
        add_access(1'b1, {(ADDR_W/2){2'b10}});
        add_access(1'b1, 64'h0000_0000_0000_0001);
        recent = '{'0, '1, {(ADDR_W/2){2'b01}}, {(ADDR_W/2){2'b10}},
                   64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000};

        // Misses mostly revisit recently recorded addresses so that runs of followers come out.
        misses = 0;
        while (misses < MISS_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                if ($urandom_range(1) == 0) begin
                    add_access(1'b0, {$urandom, $urandom});
                end else begin
                    add_access(1'b0, recent[$urandom_range(recent.size() - 1)]);
                end
            end else if (pick < 62) begin
                addr = {$urandom, $urandom};
                add_access(1'b1, addr);
                recent.push_back(addr);
                if (recent.size() > STORE_DEPTH) begin
                    void'(recent.pop_front());
                end
                misses++;
            end else begin
                add_access(1'b1, recent[$urandom_range(recent.size() - 1)]);
                misses++;
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        do begin
            @(posedge aclk);
        end while (pending_words.size() > 0 || s_valid || expected_prefetches.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
        end else if (!s_valid || s_ready) begin
            if (sent_count == PAUSE_AT && !pause_done) begin
                s_valid <= 1'b0;
                if (!s_valid && expected_prefetches.size() == 0) begin
                    pause_done <= 1'b1;
                end
            end else if (pending_words.size() > 0 &&
                         (busy_stretch || $urandom_range(99) >= IDLE_PCT)) begin
                s_valid <= 1'b1;
                s_data <= pending_words.pop_front();
                sent_count <= sent_count + 1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // The receiver stops once for a long stretch so that the input side backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && in_accepted >= HOLD_AT) begin
            m_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= busy_stretch || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin : monitor_p
        out_word_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_prefetches.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual addr %h last %b",
                             $time, m_data.prefetch_address, m_data.last_of_run);
                    errors++;
                end else begin
                    want = expected_prefetches.pop_front();
                    if (m_data.prefetch_address !== want.prefetch_address) begin
                        $display("%0t: prefetch_address mismatch, expected %h, actual %h",
                                 $time, want.prefetch_address, m_data.prefetch_address);
                        errors++;
                    end
                    if (m_data.last_of_run !== want.last_of_run) begin
                        $display("%0t: last_of_run mismatch, expected %b, actual %b",
                                 $time, want.last_of_run, m_data.last_of_run);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_access(s_data);
                in_accepted <= in_accepted + 1;
            end
        end
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/mhp_pkg.sv
design/mhp_front.sv
design/mhp_back.sv
design/miss_history_prefetcher_core.sv
tb/tb_miss_history_prefetcher_core.sv
